// ===== sv/periodic_task_tick_scheduler_top_macros.svh =====
`ifndef PERIODIC_TASK_TICK_SCHEDULER_TOP_MACROS_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_TOP_MACROS_SVH

// same-cycle implication
`define PTTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptts assertion failed");

// next-cycle implication
`define PTTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptts assertion failed");

`endif

// ===== sv/ptts_pkg.sv =====
`timescale 1ns / 1ps

package ptts_pkg;

    localparam int TASK_SLOTS  = 8;
    localparam int MAX_RESULTS = 8;
    localparam int QUEUE_DEPTH = 2;  // power of two

    localparam int IDX_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CNT_W     = $clog2(TASK_SLOTS + 1);
    localparam int RES_W     = $clog2(MAX_RESULTS + 1);
    localparam int QPTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

    localparam int ACTION_W  = 3;
    localparam int SLOT_W    = 3;
    localparam int TIME_W    = 16;
    localparam int HANDLE_W  = 8;
    localparam int KIND_W    = 2;

    localparam logic [ACTION_W-1:0] ACT_TICK    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_CREATE  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_SUSPEND = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_RESUME  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DELETE  = 3'd4;

    localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REFUSE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DUE    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_IDLE   = 2'd3;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_CREATE,
        OP_SUSPEND,
        OP_RESUME,
        OP_DELETE,
        OP_NONE
    } t_op;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SLOT_W-1:0]   slot;
        logic [TIME_W-1:0]   period;
        logic [TIME_W-1:0]   first_delay;
        logic [HANDLE_W-1:0] task_handle;
    } t_in;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [SLOT_W-1:0]   due_slot;
        logic [HANDLE_W-1:0] due_handle;
        logic                last;
    } t_out;

    typedef struct packed {
        t_op                 op;
        logic                slot_ok;
        logic [IDX_W-1:0]    addr;
        logic [TIME_W-1:0]   period;
        logic [TIME_W-1:0]   first_delay;
        logic [HANDLE_W-1:0] task_handle;
    } t_cmd;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   period;
        logic [TIME_W-1:0]   countdown;
    } t_slot_rec;

    localparam int REC_W = $bits(t_slot_rec);

    function automatic logic [IDX_W-1:0] f_slot_addr(logic [SLOT_W-1:0] s);
        logic [SLOT_W+IDX_W-1:0] w;
        w = {{IDX_W{1'b0}}, s};
        return w[IDX_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] f_slot_out(logic [IDX_W-1:0] idx);
        logic [SLOT_W+IDX_W-1:0] w;
        w = {{SLOT_W{1'b0}}, idx};
        return w[SLOT_W-1:0];
    endfunction

endpackage

// ===== sv/periodic_task_tick_scheduler_top.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake          payload
// input     in         i_valid / o_ready  i_data (t_in)
// result    out        o_valid / i_ready  o_data (t_out)
//
// Create and undefined actions: from the queue head through S_DONE to the result register.
// Tick, suspend, resume, delete: a scan of every slot in S_SCAN, one slot record read
// from the slot RAM per cycle through its single read port unless a stalled result holds it.
// A two-entry command queue lets input be taken while the back end works.
// Synchronous active-low reset empties the slot table and the queue.
// A stalled result holds the scan at the next due slot until it is taken.

module periodic_task_tick_scheduler_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ptts_pkg::t_in i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output ptts_pkg::t_out o_data
);
    import ptts_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    t_cmd cmd;

    ptts_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_cmd_valid(cmd_valid),
        .i_cmd_ready(cmd_ready),
        .o_cmd      (cmd)
    );

    ptts_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(cmd_valid),
        .o_cmd_ready(cmd_ready),
        .i_cmd      (cmd),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data)
    );

endmodule

// ===== sv/ptts_ram.sv =====
`timescale 1ns / 1ps

module ptts_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/ptts_front.sv =====
`timescale 1ns / 1ps

module ptts_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ptts_pkg::t_in  i_data,
    output logic           o_cmd_valid,
    input  logic           i_cmd_ready,
    output ptts_pkg::t_cmd o_cmd
);
    import ptts_pkg::*;

    t_cmd              c_cmd;
    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              push;
    logic              pop;

    always_comb begin
        c_cmd.slot_ok     = int'(i_data.slot) < TASK_SLOTS;
        c_cmd.addr        = f_slot_addr(i_data.slot);
        c_cmd.period      = i_data.period;
        c_cmd.first_delay = i_data.first_delay;
        c_cmd.task_handle = i_data.task_handle;
        case (i_data.action)
            ACT_TICK:    c_cmd.op = OP_TICK;
            ACT_CREATE:  c_cmd.op = OP_CREATE;
            ACT_SUSPEND: c_cmd.op = OP_SUSPEND;
            ACT_RESUME:  c_cmd.op = OP_RESUME;
            ACT_DELETE:  c_cmd.op = OP_DELETE;
            default:     c_cmd.op = OP_NONE;
        endcase
    end

    assign o_ready     = r_cnt != QCNT_W'(QUEUE_DEPTH);
    assign o_cmd_valid = r_cnt != '0;
    assign o_cmd       = r_q[r_rp];
    assign push        = i_valid && o_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= c_cmd;
        end
    end

endmodule

// ===== sv/ptts_back.sv =====
`timescale 1ns / 1ps
`include "periodic_task_tick_scheduler_top_macros.svh"

module ptts_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    input  ptts_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output ptts_pkg::t_out o_data
);
    import ptts_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                r_state,     n_state;
    t_cmd                  r_cmd,       n_cmd;
    logic [CNT_W-1:0]      r_rd_idx,    n_rd_idx;
    logic                  r_ev,        n_ev;
    logic [IDX_W-1:0]      r_ev_idx,    n_ev_idx;
    logic [RES_W-1:0]      r_n,         n_n;
    t_out                  r_pend,      n_pend;
    logic [TASK_SLOTS-1:0] r_valid,     n_valid;
    logic [TASK_SLOTS-1:0] r_en,        n_en;
    t_out                  r_out,       n_out;
    logic                  r_out_valid, n_out_valid;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_slot_rec        ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    t_slot_rec        rec;

    logic out_free;
    logic ev_due;
    logic stall;
    logic rd_go;
    logic hit;

    ptts_ram #(
        .WIDTH (REC_W),
        .DEPTH (TASK_SLOTS),
        .ADDR_W(IDX_W)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(rec)
    );

    assign out_free    = !r_out_valid || i_ready;
    assign o_cmd_ready = r_state == S_IDLE;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;

    // slot under evaluation
    assign hit    = r_valid[r_ev_idx] && rec.handle == r_cmd.task_handle;
    assign ev_due = r_ev && r_cmd.op == OP_TICK && r_valid[r_ev_idx] && r_en[r_ev_idx]
                    && rec.countdown == '0 && r_n < RES_W'(MAX_RESULTS);
    // a new due task pushes the previous one out
    assign stall  = ev_due && r_n != '0 && !out_free;
    assign rd_go  = r_rd_idx != CNT_W'(TASK_SLOTS);

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_rd_idx    = r_rd_idx;
        n_ev        = r_ev;
        n_ev_idx    = r_ev_idx;
        n_n         = r_n;
        n_pend      = r_pend;
        n_valid     = r_valid;
        n_en        = r_en;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        ram_we      = 1'b0;
        ram_waddr   = r_ev_idx;
        ram_wdata   = rec;
        ram_re      = 1'b0;
        ram_raddr   = r_rd_idx[IDX_W-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd             = i_cmd;
                    n_pend.kind       = KIND_ACCEPT;
                    n_pend.due_slot   = '0;
                    n_pend.due_handle = '0;
                    n_pend.last       = 1'b0;
                    n_rd_idx          = '0;
                    n_ev              = 1'b0;
                    n_n               = '0;
                    n_state           = S_DONE;
                    case (i_cmd.op)
                        OP_TICK, OP_SUSPEND, OP_RESUME, OP_DELETE: begin
                            n_state = S_SCAN;
                        end
                        OP_CREATE: begin
                            if (!i_cmd.slot_ok || r_valid[i_cmd.addr]) begin
                                n_pend.kind = KIND_REFUSE;
                            end else begin
                                ram_we              = 1'b1;
                                ram_waddr           = i_cmd.addr;
                                ram_wdata.handle    = i_cmd.task_handle;
                                ram_wdata.period    = i_cmd.period;
                                ram_wdata.countdown = i_cmd.first_delay;
                                n_valid[i_cmd.addr] = 1'b1;
                                n_en[i_cmd.addr]    = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (!stall) begin
                    if (r_ev) begin
                        case (r_cmd.op)
                            OP_TICK: begin
                                if (ev_due) begin
                                    if (r_n != '0) begin
                                        n_out       = r_pend;
                                        n_out_valid = 1'b1;
                                    end
                                    n_pend.kind         = KIND_DUE;
                                    n_pend.due_slot     = f_slot_out(r_ev_idx);
                                    n_pend.due_handle   = rec.handle;
                                    n_pend.last         = 1'b0;
                                    n_n                 = r_n + RES_W'(1);
                                    ram_we              = 1'b1;
                                    ram_wdata.countdown = rec.period - TIME_W'(1);
                                end else if (r_valid[r_ev_idx] && r_en[r_ev_idx]
                                             && rec.countdown != '0) begin
                                    ram_we              = 1'b1;
                                    ram_wdata.countdown = rec.countdown - TIME_W'(1);
                                end
                            end
                            OP_SUSPEND: begin
                                if (hit) begin
                                    n_en[r_ev_idx] = 1'b0;
                                end
                            end
                            OP_RESUME: begin
                                if (hit) begin
                                    n_en[r_ev_idx] = 1'b1;
                                end
                            end
                            OP_DELETE: begin
                                if (hit) begin
                                    n_valid[r_ev_idx] = 1'b0;
                                end
                            end
                            default: ;
                        endcase
                    end
                    n_ev = rd_go;
                    if (rd_go) begin
                        ram_re   = 1'b1;
                        n_rd_idx = r_rd_idx + CNT_W'(1);
                        n_ev_idx = r_rd_idx[IDX_W-1:0];
                    end
                    if (!r_ev && !rd_go) begin
                        n_state = S_DONE;
                        if (r_cmd.op == OP_TICK && r_n == '0) begin
                            n_pend.kind = KIND_IDLE;
                        end
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out       = r_pend;
                    n_out.last  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_en        <= '0;
            r_out_valid <= 1'b0;
            r_ev        <= 1'b0;
            r_rd_idx    <= '0;
            r_n         <= '0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_en        <= n_en;
            r_out_valid <= n_out_valid;
            r_ev        <= n_ev;
            r_rd_idx    <= n_rd_idx;
            r_n         <= n_n;
            r_ev_idx    <= n_ev_idx;
            r_cmd       <= n_cmd;
            r_pend      <= n_pend;
            r_out       <= n_out;
        end
    end

    `PTTS_ASSERT_IMP(a_res_cap, i_clk, i_rst_n, 1'b1, r_n <= RES_W'(MAX_RESULTS))
    `PTTS_ASSERT_NXT(a_cmd_take, i_clk, i_rst_n, i_cmd_valid && o_cmd_ready, r_state != S_IDLE)
    `PTTS_ASSERT_IMP(a_pend_due, i_clk, i_rst_n, r_state == S_SCAN && r_n != '0, r_pend.kind == KIND_DUE)
    `PTTS_ASSERT_IMP(a_ram_port, i_clk, i_rst_n, ram_we && ram_re, ram_waddr != ram_raddr)

endmodule
